// ----- rtl/core/ftsr_pkg.sv -----
`timescale 1ns / 1ps

package ftsr_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    PH_PREV_SIZE,
    PH_TYPE,
    PH_BODY_SIZE,
    PH_TIMESTAMP,
    PH_STREAM_ID,
    PH_BODY
  } phase_t;

  localparam int unsigned BURST_MAX = 5;
  localparam int unsigned BURST_CNT_W = $clog2(BURST_MAX + 1);

  typedef logic [BURST_CNT_W-1:0] burst_cnt_t;

  localparam logic [1:0] PREV_SIZE_LAST = 2'd3;
  localparam logic [1:0] BODY_SIZE_LAST = 2'd2;
  localparam logic [1:0] TIMESTAMP_LAST = 2'd3;
  localparam logic [1:0] STREAM_ID_LAST = 2'd2;

endpackage

// ----- rtl/core/ftsr_if.sv -----
`timescale 1ns / 1ps

interface ftsr_in_if;
  logic              valid;
  logic              ready;
  ftsr_pkg::byte_t   data_byte;
  logic              file_end;
  logic              join_end;

  modport source (output valid, output data_byte, output file_end, output join_end,
                  input ready);
  modport sink (input valid, input data_byte, input file_end, input join_end,
                output ready);
endinterface

interface ftsr_out_if;
  logic              valid;
  logic              ready;
  ftsr_pkg::byte_t   out_byte;
  logic              last;
  logic              stream_id_error;

  modport source (output valid, output out_byte, output last, output stream_id_error,
                  input ready);
  modport sink (input valid, input out_byte, input last, input stream_id_error,
                output ready);
endinterface

// ----- rtl/core/flv_tag_timestamp_rebaser.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Word
// in_ch     in   valid/ready    data_byte[7:0], file_end, join_end
// out_ch    out  valid/ready    out_byte[7:0], last, stream_id_error
//
// An input word is parsed in the cycle it is accepted; its 0 to 5 output words
// sit in a burst register and leave one per cycle from the next cycle on.
// A new input word is taken while the final word of the previous burst leaves,
// so the input rate is one word per cycle when each word yields at most one.
// rst_n is synchronous, active low; it clears the parser and the burst count.
// out_ch stalls hold the burst; in_ch ready drops until the burst drains.

module flv_tag_timestamp_rebaser (
  input  logic          clk,
  input  logic          rst_n,
  ftsr_in_if.sink       in_ch,
  ftsr_out_if.source    out_ch
);

  ftsr_pkg::phase_t     phase_r, phase_nxt;
  logic [1:0]           pos_r, pos_nxt;
  logic [31:0]          held_prev_r, held_prev_nxt;
  logic [31:0]          held_ts_r, held_ts_nxt;
  logic [23:0]          body_r, body_nxt;
  logic [31:0]          offset_r, offset_nxt;
  logic [31:0]          last_reb_r, last_reb_nxt;
  logic [31:0]          rec_prev_r, rec_prev_nxt;

  ftsr_pkg::byte_t      burst_r [ftsr_pkg::BURST_MAX];
  ftsr_pkg::byte_t      burst_nxt [ftsr_pkg::BURST_MAX];
  ftsr_pkg::burst_cnt_t burst_cnt_r, burst_cnt_nxt;
  logic                 err_r, err_nxt;

  ftsr_pkg::byte_t      step_bytes [ftsr_pkg::BURST_MAX];
  ftsr_pkg::burst_cnt_t step_cnt;
  logic                 step_err;

  logic                 in_acc;
  logic                 out_acc;
  logic                 ends_file;
  logic [31:0]          ts_reb;
  logic [31:0]          rec_prev_now;
  ftsr_pkg::byte_t      b;

  assign b         = in_ch.data_byte;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign ends_file = in_ch.file_end || in_ch.join_end;
  assign ts_reb    = {b, held_ts_r[23:0]} + offset_r;
  assign rec_prev_now = (phase_r == ftsr_pkg::PH_TYPE) ? held_prev_r : rec_prev_r;

  assign in_ch.ready = (burst_cnt_r == '0) ||
                       ((burst_cnt_r == ftsr_pkg::burst_cnt_t'(1)) && out_ch.ready);

  assign out_ch.valid           = burst_cnt_r != '0;
  assign out_ch.out_byte        = burst_r[0];
  assign out_ch.last            = burst_cnt_r == ftsr_pkg::burst_cnt_t'(1);
  assign out_ch.stream_id_error = err_r;

  // parser next state
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    held_prev_nxt = held_prev_r;
    held_ts_nxt   = held_ts_r;
    body_nxt      = body_r;
    offset_nxt    = offset_r;
    last_reb_nxt  = last_reb_r;
    rec_prev_nxt  = rec_prev_r;
    if (in_acc) begin
      case (phase_r)
        ftsr_pkg::PH_TYPE: begin
          rec_prev_nxt = held_prev_r;
          body_nxt     = '0;
          phase_nxt    = ftsr_pkg::PH_BODY_SIZE;
          pos_nxt      = '0;
        end
        ftsr_pkg::PH_BODY_SIZE: begin
          body_nxt = {body_r[15:0], b};
          if (pos_r >= ftsr_pkg::BODY_SIZE_LAST) begin
            phase_nxt = ftsr_pkg::PH_TIMESTAMP;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end
        ftsr_pkg::PH_TIMESTAMP: begin
          held_ts_nxt = {held_ts_r[23:0], b};
          if (pos_r >= ftsr_pkg::TIMESTAMP_LAST) begin
            last_reb_nxt = ts_reb;
            phase_nxt    = ftsr_pkg::PH_STREAM_ID;
            pos_nxt      = '0;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end
        ftsr_pkg::PH_STREAM_ID: begin
          if (pos_r >= ftsr_pkg::STREAM_ID_LAST) begin
            phase_nxt = (body_r != '0) ? ftsr_pkg::PH_BODY : ftsr_pkg::PH_PREV_SIZE;
            pos_nxt   = '0;
          end else begin
            pos_nxt = pos_r + 2'd1;
          end
        end
        ftsr_pkg::PH_BODY: begin
          body_nxt = body_r - 24'd1;
          if (body_r == 24'd1) begin
            phase_nxt = ftsr_pkg::PH_PREV_SIZE;
            pos_nxt   = '0;
          end
        end
        default: begin
          held_prev_nxt = {held_prev_r[23:0], b};
          if (pos_r >= ftsr_pkg::PREV_SIZE_LAST) begin
            phase_nxt = ftsr_pkg::PH_TYPE;
            pos_nxt   = '0;
          end else begin
            phase_nxt = ftsr_pkg::PH_PREV_SIZE;
            pos_nxt   = pos_r + 2'd1;
          end
        end
      endcase
      if (ends_file) begin
        offset_nxt    = last_reb_nxt;
        phase_nxt     = ftsr_pkg::PH_PREV_SIZE;
        pos_nxt       = '0;
        held_prev_nxt = '0;
        held_ts_nxt   = '0;
        body_nxt      = '0;
      end
      if (in_ch.join_end) begin
        offset_nxt   = '0;
        last_reb_nxt = '0;
        rec_prev_nxt = '0;
      end
    end
  end

  // output words of the current input word
  always_comb begin
    for (int i = 0; i < ftsr_pkg::BURST_MAX; i++) begin
      step_bytes[i] = '0;
    end
    step_cnt = '0;
    step_err = 1'b0;
    case (phase_r)
      ftsr_pkg::PH_TYPE: begin
        step_bytes[0] = held_prev_r[31:24];
        step_bytes[1] = held_prev_r[23:16];
        step_bytes[2] = held_prev_r[15:8];
        step_bytes[3] = held_prev_r[7:0];
        step_bytes[4] = b;
        step_cnt      = ftsr_pkg::burst_cnt_t'(5);
      end
      ftsr_pkg::PH_BODY_SIZE, ftsr_pkg::PH_BODY: begin
        step_bytes[0] = b;
        step_cnt      = ftsr_pkg::burst_cnt_t'(1);
      end
      ftsr_pkg::PH_TIMESTAMP: begin
        if (pos_r >= ftsr_pkg::TIMESTAMP_LAST) begin
          step_bytes[0] = ts_reb[23:16];
          step_bytes[1] = ts_reb[15:8];
          step_bytes[2] = ts_reb[7:0];
          step_bytes[3] = ts_reb[31:24];
          step_cnt      = ftsr_pkg::burst_cnt_t'(4);
        end
      end
      ftsr_pkg::PH_STREAM_ID: begin
        step_err = b != '0;
        step_cnt = ftsr_pkg::burst_cnt_t'(1);
      end
      default: begin
        step_cnt = '0;
      end
    endcase
    if (in_ch.join_end) begin
      step_bytes[0] = rec_prev_now[31:24];
      step_bytes[1] = rec_prev_now[23:16];
      step_bytes[2] = rec_prev_now[15:8];
      step_bytes[3] = rec_prev_now[7:0];
      step_cnt      = ftsr_pkg::burst_cnt_t'(4);
    end
  end

  // load or advance the burst
  always_comb begin
    burst_cnt_nxt = burst_cnt_r;
    err_nxt       = err_r;
    for (int i = 0; i < ftsr_pkg::BURST_MAX; i++) begin
      burst_nxt[i] = burst_r[i];
    end
    if (in_acc) begin
      burst_cnt_nxt = step_cnt;
      err_nxt       = step_err;
      for (int i = 0; i < ftsr_pkg::BURST_MAX; i++) begin
        burst_nxt[i] = step_bytes[i];
      end
    end else if (out_acc) begin
      burst_cnt_nxt = burst_cnt_r - ftsr_pkg::burst_cnt_t'(1);
      for (int i = 0; i < ftsr_pkg::BURST_MAX - 1; i++) begin
        burst_nxt[i] = burst_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ftsr_pkg::PH_PREV_SIZE;
      pos_r       <= '0;
      held_prev_r <= '0;
      held_ts_r   <= '0;
      body_r      <= '0;
      offset_r    <= '0;
      last_reb_r  <= '0;
      rec_prev_r  <= '0;
      burst_cnt_r <= '0;
      err_r       <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      held_prev_r <= held_prev_nxt;
      held_ts_r   <= held_ts_nxt;
      body_r      <= body_nxt;
      offset_r    <= offset_nxt;
      last_reb_r  <= last_reb_nxt;
      rec_prev_r  <= rec_prev_nxt;
      burst_cnt_r <= burst_cnt_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ftsr_pkg::BURST_MAX; i++) begin
      burst_r[i] <= burst_nxt[i];
    end
  end

endmodule

// ----- rtl/core/ftsr_checker.sv -----
`timescale 1ns / 1ps

module ftsr_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_join_end,
  input logic            out_valid,
  input logic            out_ready,
  input ftsr_pkg::byte_t out_byte,
  input logic            out_last,
  input logic            out_stream_id_error
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");

  a_in_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !out_valid || (out_ready && out_last))
    else $error("input word taken while burst pending");

  a_join_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_join_end |=> out_valid)
    else $error("join end gave no output");

  a_err_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_last |=> out_valid &&
      out_stream_id_error == $past(out_stream_id_error))
    else $error("burst broken or error flag changed within burst");

endmodule

bind flv_tag_timestamp_rebaser ftsr_checker u_ftsr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .in_join_end         (in_ch.join_end),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_byte            (out_ch.out_byte),
  .out_last            (out_ch.last),
  .out_stream_id_error (out_ch.stream_id_error)
);
